[src/swsnd_pkg.sv]
// Shared types and constants of the sliding window sender.
package swsnd_pkg;

  localparam int unsigned RES_CAP = 32;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_EOD  = 2'd2,
    KIND_TICK = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ACT_SEND   = 3'd0,
    ACT_RESEND = 3'd1,
    ACT_DISC   = 3'd2,
    ACT_REDISC = 3'd3,
    ACT_REFUSE = 3'd4,
    ACT_CLOSED = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    PH_SENDING = 2'd0,
    PH_DISC    = 2'd1,
    PH_CLOSED  = 2'd2
  } phase_t;

  typedef enum logic [0:0] {
    REG_TIMEOUT = 1'b0,
    REG_INIT_WIN = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic        busy;
    logic [7:0]  seq;
    logic [9:0]  len;
    logic [15:0] age;
  } slot_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  seq;
    logic [4:0]  slot;
    logic [9:0]  len;
    logic [4:0]  cred;
  } res_t;

endpackage

[src/swsnd_cell.sv]
// One slot of the outstanding-packet ring.
module swsnd_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  swsnd_pkg::slot_t shift_in,
  input  logic            load,
  input  swsnd_pkg::slot_t load_data,
  output swsnd_pkg::slot_t q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= shift_in;
    end else if (load) begin
      q <= load_data;
    end
    if (rst) begin
      q.busy <= 1'b0;
    end
  end

endmodule

[src/sliding_window_sender.sv]
// Top level of the sliding window sender.
//
// Send side of a selective-repeat ARQ. One input transaction carries an event:
// an acknowledgement, a data offer, end of data or a one millisecond tick.
// Each event yields zero or more result transactions on the output channel;
// the last one of an event has last set. Configuration (timeout and initial
// window) is written through the cfg channel while the block is idle.
// Outstanding packets live in a ring of SLOTS cells. A valid acknowledgement
// or a tick in the sending phase rotates the ring once around, one slot per
// cycle while the output does not hold it up, through a single update unit at
// its head. Such an event goes through S_SCAN, S_FIN and S_DRAIN, which
// registers its last result, before the next event can be taken. A data
// offer, or any event that sends a disconnect, a resend of it or the close
// without a scan, goes straight from S_IDLE to S_DRAIN, which registers its
// result once the output is free. An event with no result outside a scan stays
// in S_IDLE. A new event is accepted only once all results of the previous one
// have left the staging register. When the receiver stalls, the ring stops
// rotating once a result at its head finds the staging register full, so no
// result is lost. Reset empties all slots, sets the window and credit to one
// and the sequence number to zero; slot sequence, length and age are not cleared.
module sliding_window_sender #(
  parameter int unsigned SLOTS       = 32,
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  ack_seq,
  input  logic [4:0]  ack_window,
  input  logic        ack_ok,
  input  logic [9:0]  data_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic [7:0]  seq,
  output logic [4:0]  slot,
  output logic [9:0]  length,
  output logic [4:0]  advertised_credit,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FIN   = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t state;
  swsnd_pkg::phase_t phase;
  logic [15:0] timeout_ticks;
  logic [5:0]  free_credit;
  logic [4:0]  window_size;
  logic        window_learned;
  logic [7:0]  next_seq;
  logic        data_done;
  logic [15:0] disc_age;
  logic        scan_tick;
  logic [7:0]  ack_seq_r;
  logic [IW-1:0] cnt;
  logic [5:0]  rescnt;
  swsnd_pkg::res_t pend;
  logic        pend_valid;

  swsnd_pkg::slot_t cq [SLOTS];
  swsnd_pkg::slot_t head_next;
  logic        shift;
  logic [SLOTS-1:0] load_en;
  swsnd_pkg::slot_t load_data;
  logic [SLOTS-1:0] busy_vec;

  // The ring of slot cells; cell 0 is the head seen by the update unit.
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    swsnd_pkg::slot_t sin;
    if (g == SLOTS - 1) begin : g_wrap
      assign sin = head_next;
    end else begin : g_mid
      assign sin = cq[g+1];
    end
    swsnd_cell u_cell (
      .clk(clk), .rst(rst), .shift(shift), .shift_in(sin),
      .load(load_en[g]), .load_data(load_data), .q(cq[g])
    );
    assign busy_vec[g] = cq[g].busy;
  end

  logic any_busy;
  assign any_busy = |busy_vec;

  // First free slot for a data offer.
  logic          free_found;
  logic [IW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_vec[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  logic [4:0] cred_out;
  assign cred_out = (free_credit > 6'd31) ? 5'd31 : free_credit[4:0];

  logic out_free;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // Update unit at the head of the ring.
  logic [7:0] seq_dist;
  logic       head_free, head_emit;
  swsnd_pkg::res_t head_res;
  always_comb begin
    head_next = cq[0];
    seq_dist  = ack_seq_r - cq[0].seq;
    head_free = 1'b0;
    head_emit = 1'b0;
    head_res  = '{action: swsnd_pkg::ACT_RESEND, seq: cq[0].seq,
                  slot: 5'(cnt), len: cq[0].len, cred: 5'd0};
    if (cq[0].busy) begin
      if (!scan_tick) begin
        if (seq_dist >= 8'd1 && seq_dist <= {3'd0, window_size}) begin
          head_next.busy = 1'b0;
          head_free      = 1'b1;
        end
      end else if (cq[0].age >= timeout_ticks) begin
        if (rescnt < 6'(swsnd_pkg::RES_CAP)) begin
          head_emit     = 1'b1;
          head_next.age = '0;
        end
      end else begin
        head_next.age = cq[0].age + 16'd1;
      end
    end
  end

  logic step;
  assign step  = (state == S_SCAN) && !(head_emit && pend_valid && !out_free);
  assign shift = step;

  logic accept;
  assign accept = in_valid && in_ready;

  logic offer_ok;
  assign offer_ok = (phase == swsnd_pkg::PH_SENDING) && !data_done && (free_credit != 6'd0)
                    && (data_length != 10'd0)
                    && ({3'd0, data_length} <= 13'(MAX_PAYLOAD)) && free_found;

  always_comb begin
    load_data = '{busy: 1'b1, seq: next_seq, len: data_length, age: 16'd0};
    load_en   = '0;
    if (accept && kind == swsnd_pkg::KIND_DATA && offer_ok) begin
      load_en[free_idx] = 1'b1;
    end
  end

  logic signed [7:0] learn_c;
  assign learn_c = $signed({2'b0, free_credit}) + $signed({3'b0, ack_window})
                   - $signed({3'b0, window_size});

  always_ff @(posedge clk) begin
    // Output register.
    if (step && head_emit && pend_valid) begin
      out_valid <= 1'b1;
      action <= pend.action; seq <= pend.seq; slot <= pend.slot;
      length <= pend.len; advertised_credit <= pend.cred; last <= 1'b0;
    end else if (state == S_DRAIN && pend_valid && out_free) begin
      out_valid <= 1'b1;
      action <= pend.action; seq <= pend.seq; slot <= pend.slot;
      length <= pend.len; advertised_credit <= pend.cred; last <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == swsnd_pkg::REG_TIMEOUT) begin
        timeout_ticks <= cfg_data;
      end else begin
        if (!window_learned && phase == swsnd_pkg::PH_SENDING && !any_busy) begin
          window_size <= cfg_data[4:0];
          free_credit <= {1'b0, cfg_data[4:0]};
        end
      end
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          ack_seq_r <= ack_seq;
          rescnt    <= '0;
          cnt       <= '0;
          case (kind)
            swsnd_pkg::KIND_ACK: begin
              scan_tick <= 1'b0;
              if (ack_ok && phase == swsnd_pkg::PH_SENDING) begin
                if (!window_learned && ack_window != window_size) begin
                  free_credit <= (learn_c < 0) ? 6'd0 :
                                 (learn_c > 8'sd63) ? 6'd63 : learn_c[5:0];
                  window_size <= ack_window;
                  window_learned <= 1'b1;
                end
                state <= S_SCAN;
              end else if (ack_ok && phase == swsnd_pkg::PH_DISC && ack_window == 5'd0) begin
                phase      <= swsnd_pkg::PH_CLOSED;
                pend       <= '{swsnd_pkg::ACT_CLOSED, 8'd0, 5'd0, 10'd0, 5'd0};
                pend_valid <= 1'b1;
                state      <= S_DRAIN;
              end
            end
            swsnd_pkg::KIND_DATA: begin
              pend_valid <= 1'b1;
              state      <= S_DRAIN;
              if (offer_ok) begin
                pend <= '{swsnd_pkg::ACT_SEND, next_seq, 5'(free_idx), data_length, cred_out};
                free_credit <= free_credit - 6'd1;
                next_seq    <= next_seq + 8'd1;
              end else begin
                pend <= '{swsnd_pkg::ACT_REFUSE, 8'd0, 5'd0, 10'd0, 5'd0};
              end
            end
            swsnd_pkg::KIND_EOD: begin
              if (phase == swsnd_pkg::PH_SENDING && !data_done) begin
                data_done <= 1'b1;
                if (!any_busy) begin
                  phase      <= swsnd_pkg::PH_DISC;
                  disc_age   <= '0;
                  pend       <= '{swsnd_pkg::ACT_DISC, next_seq, 5'd0, 10'd0, cred_out};
                  pend_valid <= 1'b1;
                  state      <= S_DRAIN;
                end
              end
            end
            default: begin
              scan_tick <= 1'b1;
              if (phase == swsnd_pkg::PH_SENDING) begin
                state <= S_SCAN;
              end else if (phase == swsnd_pkg::PH_DISC) begin
                if (disc_age >= timeout_ticks) begin
                  disc_age   <= '0;
                  pend       <= '{swsnd_pkg::ACT_REDISC, next_seq, 5'd0, 10'd0, 5'd0};
                  pend_valid <= 1'b1;
                  state      <= S_DRAIN;
                end else begin
                  disc_age <= disc_age + 16'd1;
                end
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (step) begin
          if (head_free && free_credit < 6'd63) begin
            free_credit <= free_credit + 6'd1;
          end
          if (head_emit) begin
            pend       <= head_res;
            pend_valid <= 1'b1;
            rescnt     <= rescnt + 6'd1;
          end
          cnt <= cnt + IW'(1);
          if (cnt == IW'(SLOTS - 1)) begin
            state <= S_FIN;
          end
        end
      end
      S_FIN: begin
        // The ring is back in slot order; see whether the last ack emptied it.
        if (!scan_tick && data_done && !any_busy) begin
          phase      <= swsnd_pkg::PH_DISC;
          disc_age   <= '0;
          pend       <= '{swsnd_pkg::ACT_DISC, next_seq, 5'd0, 10'd0, cred_out};
          pend_valid <= 1'b1;
        end
        state <= S_DRAIN;
      end
      S_DRAIN: begin
        if (!pend_valid) begin
          state <= S_IDLE;
        end else if (out_free) begin
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end
      end
      default: state <= S_IDLE;
    endcase

    if (rst) begin
      state          <= S_IDLE;
      phase          <= swsnd_pkg::PH_SENDING;
      timeout_ticks  <= 16'd1000;
      free_credit    <= 6'd1;
      window_size    <= 5'd1;
      window_learned <= 1'b0;
      next_seq       <= '0;
      data_done      <= 1'b0;
      pend_valid     <= 1'b0;
      out_valid      <= 1'b0;
      scan_tick      <= 1'b0;
      cnt            <= '0;
      rescnt         <= '0;
      disc_age       <= '0;
    end
  end

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pend_valid) else $error("staging register busy while idle");
  a_closed_stays: assert property (@(posedge clk) disable iff (rst)
    phase == swsnd_pkg::PH_CLOSED |=> phase == swsnd_pkg::PH_CLOSED)
    else $error("left closed phase");
  a_res_cap: assert property (@(posedge clk) disable iff (rst)
    rescnt <= 6'(swsnd_pkg::RES_CAP)) else $error("resend count above cap");
  a_scan_shift: assert property (@(posedge clk) disable iff (rst)
    shift |-> state == S_SCAN && !accept) else $error("ring moved outside a scan");

endmodule
